// File: hdl/dmsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmsc_pkg - shared types for the direct-mapped search cache
// Command, table slot and result layouts, operation and bound codes.
// ----------------------------------------------------------------------------
package dmsc_pkg;

  typedef enum logic [1:0] {
    OP_PROBE = 2'd0,
    OP_STORE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [1:0] BOUND_EXACT = 2'd0;
  localparam logic [1:0] BOUND_LOWER = 2'd1;
  localparam logic [1:0] BOUND_UPPER = 2'd2;

  // one queued transaction
  typedef struct packed {
    op_t                op;
    logic [63:0]        key;
    logic signed [15:0] value;
    logic [15:0]        move;
    logic [7:0]         depth;
    logic [1:0]         bound;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
  } cmd_t;

  // 50-bit data word: age, bound, depth, move, value (msb to lsb)
  typedef struct packed {
    logic [7:0]         age;
    logic [1:0]         bound;
    logic [7:0]         depth;
    logic [15:0]        move;
    logic signed [15:0] value;
  } entry_t;

  typedef struct packed {
    logic [63:0] key;
    entry_t      data;
  } slot_t;

  typedef struct packed {
    logic               hit;
    logic               cutoff;
    logic signed [15:0] value;
    logic [15:0]        move;
    logic [7:0]         depth;
    logic [1:0]         bound;
    logic               replaced;
  } res_t;

  // back end to front end
  typedef struct packed {
    logic pop;
    logic busy;
  } back_ctrl_t;

  localparam int QDEPTH = 2;

endpackage : dmsc_pkg
`default_nettype wire

// File: hdl/dmsc_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmsc_table - slot memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dmsc_table import dmsc_pkg::*; #(
  parameter int IDX_W = 12
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output slot_t                 rd_data,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire slot_t            wr_data
);

  slot_t mem [2**IDX_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : dmsc_table
`default_nettype wire

// File: hdl/dmsc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmsc_front - input side
// Accepts transactions, decodes the operation and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module dmsc_front import dmsc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         operation,
  input  wire logic [63:0]        key,
  input  wire logic signed [15:0] value,
  input  wire logic [15:0]        move_word,
  input  wire logic [7:0]         search_depth,
  input  wire logic [1:0]         bound_kind,
  input  wire logic signed [15:0] alpha,
  input  wire logic signed [15:0] beta,
  output logic                    q_valid,
  output cmd_t                    q_head,
  input  wire back_ctrl_t         ctrl
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  cmd_t             queue [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  cmd_t             cmd_in;

  always_comb begin
    cmd_in.op    = op_t'(operation);
    cmd_in.key   = key;
    cmd_in.value = value;
    cmd_in.move  = move_word;
    cmd_in.depth = search_depth;
    cmd_in.bound = bound_kind;
    cmd_in.alpha = alpha;
    cmd_in.beta  = beta;
  end

  // no intake while the table is being wiped after reset
  assign in_ready = (count != CNT_W'(QDEPTH)) && !ctrl.busy;
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign q_head   = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (ctrl.pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, ctrl.pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule : dmsc_front
`default_nettype wire

// File: hdl/dmsc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmsc_back - execution engine
// Reads the slot, evaluates probe or store, writes back, sweeps the table
// on clear and after reset, and holds the result register.
// ----------------------------------------------------------------------------
module dmsc_back import dmsc_pkg::*; #(
  parameter int IDX_W = 12
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  input  wire cmd_t             cmd,
  output back_ctrl_t            ctrl,
  input  wire logic             cfg_wr_en,
  input  wire logic [7:0]       cfg_wr_data,
  output logic                  rd_en,
  output logic [IDX_W-1:0]      rd_addr,
  input  wire slot_t            rd_data,
  output logic                  wr_en,
  output logic [IDX_W-1:0]      wr_addr,
  output slot_t                 wr_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output res_t                  res
);

  typedef enum logic [1:0] {S_INIT, S_IDLE, S_EXEC, S_CLEAR} state_t;

  state_t           state;
  logic [IDX_W-1:0] clr_idx;
  logic [7:0]       search_age;

  logic [IDX_W-1:0] idx;
  logic             out_free;
  logic             start;
  logic             sweep;
  logic             sweep_last;
  logic             clear_done;
  logic             res_load;
  logic             key_match;
  logic             bound_ok;
  logic             replace;
  logic             do_store;
  entry_t           ent;
  slot_t            new_slot;
  res_t             exec_res;
  res_t             clear_res;

  assign idx      = cmd.key[IDX_W-1:0];
  assign ent      = rd_data.data;
  assign out_free = !out_valid || out_ready;
  assign start    = (state == S_IDLE) && q_valid && out_free;
  assign sweep    = (state == S_INIT) || (state == S_CLEAR);
  assign sweep_last = sweep && (&clr_idx);
  assign clear_done = (state == S_CLEAR) && sweep_last;
  // result register loads at the end of evaluation or of a clear walk
  assign res_load   = (state == S_EXEC) || clear_done;

  assign rd_en   = start && (cmd.op != OP_CLEAR);
  assign rd_addr = idx;

  assign key_match = (rd_data.key == cmd.key);

  always_comb begin
    case (ent.bound)
      BOUND_EXACT: bound_ok = 1'b1;
      BOUND_LOWER: bound_ok = (ent.value >= cmd.beta);
      BOUND_UPPER: bound_ok = (ent.value <= cmd.alpha);
      default:     bound_ok = 1'b0;
    endcase
  end

  assign replace  = (rd_data.key == '0) || (ent.age != search_age) ||
                    (cmd.depth >= ent.depth);
  assign do_store = (state == S_EXEC) && (cmd.op == OP_STORE) && replace;

  always_comb begin
    new_slot.key        = cmd.key;
    new_slot.data.age   = search_age;
    new_slot.data.bound = cmd.bound;
    new_slot.data.depth = cmd.depth;
    new_slot.data.move  = cmd.move;
    new_slot.data.value = cmd.value;
  end

  assign wr_en   = do_store || sweep;
  assign wr_addr = sweep ? clr_idx : idx;
  assign wr_data = sweep ? slot_t'('0) : new_slot;

  always_comb begin
    exec_res = '0;
    case (cmd.op)
      OP_PROBE: begin
        if (key_match) begin
          exec_res.hit    = 1'b1;
          exec_res.cutoff = (ent.depth >= cmd.depth) && bound_ok;
          exec_res.value  = ent.value;
          exec_res.move   = ent.move;
          exec_res.depth  = ent.depth;
          exec_res.bound  = ent.bound;
        end
      end
      OP_STORE: exec_res.replaced = replace;
      default:  exec_res = '0;
    endcase
  end

  always_comb begin
    clear_res          = '0;
    clear_res.replaced = 1'b1;
  end

  assign ctrl.pop  = res_load;
  assign ctrl.busy = (state == S_INIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      clr_idx    <= '0;
      search_age <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (clear_done) begin
        search_age <= '0;
      end else if (cfg_wr_en) begin
        search_age <= cfg_wr_data;
      end
      unique case (state)
        S_INIT: begin
          clr_idx <= clr_idx + IDX_W'(1);
          if (sweep_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            state <= (cmd.op == OP_CLEAR) ? S_CLEAR : S_EXEC;
          end
        end
        S_EXEC: begin
          res   <= exec_res;
          state <= S_IDLE;
        end
        S_CLEAR: begin
          clr_idx <= clr_idx + IDX_W'(1);
          if (sweep_last) begin
            res   <= clear_res;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register is free whenever evaluation lands
  a_exec_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |-> !out_valid)
    else $error("result overwritten before it was taken");

  a_pop_has_item: assert property (@(posedge clk) disable iff (rst)
    ctrl.pop |-> q_valid)
    else $error("pop from empty queue");

  a_exec_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |=> (state == S_IDLE))
    else $error("evaluation did not return to idle");

  a_cutoff_needs_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!res.cutoff || res.hit) && !(res.hit && res.replaced))
    else $error("inconsistent result flags");

  a_no_result_in_init: assert property (@(posedge clk) disable iff (rst)
    (state == S_INIT) |-> !out_valid)
    else $error("result during reset sweep");

endmodule : dmsc_back
`default_nettype wire

// File: hdl/direct_mapped_search_cache.sv
`default_nettype none
// ----------------------------------------------------------------------------
// direct_mapped_search_cache - transposition table, depth-preferred
// Direct-mapped table of search results with probe, store and clear.
// ----------------------------------------------------------------------------
// A probe or store passes through the engine as the slot memory read
// (registered read data), then evaluation, write back and loading of the
// result register; the engine takes no new transaction until it is back
// in idle. A clear is issued from idle and then walks the slot memory
// one entry a cycle, returning its done marker at the end of the walk and
// resetting search_age to zero.
// After reset the same walk covers every entry with in_ready low;
// configuration writes are taken throughout. A two-entry queue sits between
// intake and engine, and the result register frees on the cycle it is taken,
// so input and output stall independently. Slot index is the low
// log2(TABLE_ENTRIES) bits of the key; TABLE_ENTRIES must be a power of two.
// ----------------------------------------------------------------------------
module direct_mapped_search_cache import dmsc_pkg::*; #(
  parameter int TABLE_ENTRIES = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration: search_age
  input  wire logic               cfg_wr_en,
  input  wire logic [7:0]         cfg_wr_data,
  // request channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         operation,
  input  wire logic [63:0]        key,
  input  wire logic signed [15:0] value,
  input  wire logic [15:0]        move_word,
  input  wire logic [7:0]         search_depth,
  input  wire logic [1:0]         bound_kind,
  input  wire logic signed [15:0] alpha,
  input  wire logic signed [15:0] beta,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    hit,
  output logic                    cutoff,
  output logic signed [15:0]      found_value,
  output logic [15:0]             found_move,
  output logic [7:0]              found_depth,
  output logic [1:0]              found_bound,
  output logic                    replaced
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  logic             q_valid;
  cmd_t             q_head;
  back_ctrl_t       ctrl;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  slot_t            rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  slot_t            wr_data;
  res_t             res;

  // intake and decode
  dmsc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .key          (key),
    .value        (value),
    .move_word    (move_word),
    .search_depth (search_depth),
    .bound_kind   (bound_kind),
    .alpha        (alpha),
    .beta         (beta),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .ctrl         (ctrl)
  );

  // engine: read, evaluate, write back, sweep
  dmsc_back #(.IDX_W(IDX_W)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .cmd         (q_head),
    .ctrl        (ctrl),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .res         (res)
  );

  // key and data per slot, no reset: wiped by the sweep
  dmsc_table #(.IDX_W(IDX_W)) u_table (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign hit         = res.hit;
  assign cutoff      = res.cutoff;
  assign found_value = res.value;
  assign found_move  = res.move;
  assign found_depth = res.depth;
  assign found_bound = res.bound;
  assign replaced    = res.replaced;

endmodule : direct_mapped_search_cache
`default_nettype wire
